FILE: src/mic_agc_noise_gate_chain_top_defines.svh
// Assertion macros for the microphone conditioning chain checker.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef MIC_AGC_NOISE_GATE_CHAIN_TOP_DEFINES_SVH
`define MIC_AGC_NOISE_GATE_CHAIN_TOP_DEFINES_SVH
// same-cycle implication
`define MGC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mgc check failed");
// next-cycle implication
`define MGC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mgc check failed");
`endif

FILE: src/mgc_pkg.sv
// Types, constants and helpers of the microphone conditioning chain.
// No dependencies.
`default_nettype none
package mgc_pkg;
  localparam int SigW      = 40;
  localparam int MulAW     = 44;
  localparam int MulBW     = 24;
  localparam int MulPW     = 68;
  localparam int DigW      = 4;
  localparam int MulDigits = MulBW / DigW;
  localparam int DvdW      = 57;
  localparam int DvsW      = 41;
  localparam int LimW      = 42;

  typedef logic signed [SigW-1:0]  sig_t;
  typedef logic signed [MulPW-1:0] wide_t;
  typedef logic signed [LimW-1:0]  lim_t;

  typedef struct packed {
    logic             start;
    logic [MulAW-1:0] a;
    logic [MulBW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [MulPW-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dvd;
    logic [DvsW-1:0] dvs;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DvdW-1:0] q;
  } div_rsp_t;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_DONE} state_t;

  typedef enum logic [3:0] {
    STP_DC, STP_HP, STP_LP, STP_PK1, STP_PK2, STP_AIM, STP_SLEW, STP_GAIN,
    STP_USER, STP_ENV1, STP_ENV2, STP_GMUL, STP_GDIV, STP_FIN
  } step_t;

  typedef enum logic [2:0] {
    CFG_TARGET_PEAK, CFG_GAIN_FLOOR, CFG_GAIN_CEILING, CFG_SLEW_RATE, CFG_VOLUME_STEP
  } cfg_idx_t;

  localparam logic [MulBW-1:0] K_DC        = 24'd65208;
  localparam logic [MulBW-1:0] K_HP        = 24'd62980;
  localparam logic [MulBW-1:0] K_LP        = 24'd29491;
  localparam logic [MulBW-1:0] K_ATK_KEEP  = 24'd55706;
  localparam logic [MulBW-1:0] K_ATK_NEW   = 24'd9830;
  localparam logic [MulBW-1:0] K_REL_KEEP  = 24'd65516;
  localparam logic [MulBW-1:0] K_REL_NEW   = 24'd20;
  localparam logic [MulBW-1:0] K_ENV_KEEP  = 24'd62259;
  localparam logic [MulBW-1:0] K_ENV_NEW   = 24'd3277;
  localparam logic [17:0]      K_USER_BASE = 18'd32768;
  localparam logic [17:0]      K_USER_STEP = 18'd9830;

  localparam logic [SigW-1:0] GATE_LOW  = 40'd64000;
  localparam logic [SigW-1:0] GATE_HIGH = 40'd179200;
  localparam logic [DvsW-1:0] GATE_SPAN = 41'd115200;
  localparam lim_t LIM_KNEE = 42'sd7168000;
  localparam lim_t PCM_HI   = 42'sd8388352;
  localparam lim_t PCM_LO   = -42'sd8388608;

  localparam logic [SigW-1:0] PEAK_RESET = 40'd51200000;
  localparam logic [23:0]     GAIN_RESET = 24'd512;
  localparam logic [23:0]     GAIN_MAX   = 24'hFFFFFF;

  localparam wide_t SIG_MAX_W = 68'sd549755813887;
  localparam wide_t SIG_MIN_W = -68'sd549755813888;

  function automatic sig_t sat40(input wide_t v);
    sig_t r;
    if (v > SIG_MAX_W) begin
      r = 40'sh7FFFFFFFFF;
    end else if (v < SIG_MIN_W) begin
      r = 40'sh8000000000;
    end else begin
      r = v[SigW-1:0];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: src/mgc_mul.sv
// Shared digit-serial multiplier: signed A times unsigned B, four bits of B per cycle.
// Depends on mgc_pkg.
`default_nettype none
module mgc_mul (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mgc_pkg::mul_req_t req,
  output mgc_pkg::mul_rsp_t      rsp
);
  localparam int CntW = $clog2(mgc_pkg::MulDigits);

  logic signed [mgc_pkg::MulAW-1:0]        a_r;
  logic [mgc_pkg::MulBW-1:0]               b_r;
  mgc_pkg::wide_t                          acc_r;
  logic [CntW-1:0]                         cnt_r;
  logic                                    busy_r;
  logic                                    done_r;
  logic signed [mgc_pkg::MulAW+mgc_pkg::DigW:0] pp;
  mgc_pkg::wide_t                          acc_nxt;

  assign pp      = a_r * $signed({1'b0, b_r[mgc_pkg::MulBW-1 -: mgc_pkg::DigW]});
  assign acc_nxt = (acc_r <<< mgc_pkg::DigW) + mgc_pkg::MulPW'(pp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r    <= $signed(req.a);
        b_r    <= req.b;
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        b_r   <= b_r << mgc_pkg::DigW;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(mgc_pkg::MulDigits - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;
endmodule
`default_nettype wire

FILE: src/mgc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on mgc_pkg.
`default_nettype none
module mgc_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mgc_pkg::div_req_t req,
  output mgc_pkg::div_rsp_t      rsp
);
  localparam int CntW = $clog2(mgc_pkg::DvdW);

  logic [mgc_pkg::DvdW-1:0] dvd_r;
  logic [mgc_pkg::DvsW-1:0] dvs_r;
  logic [mgc_pkg::DvsW-1:0] rem_r;
  logic [CntW-1:0]          cnt_r;
  logic                     busy_r;
  logic                     done_r;
  logic [mgc_pkg::DvsW:0]   rem_sh;
  logic [mgc_pkg::DvsW:0]   rem_nxt;
  logic                     ge;

  assign rem_sh  = {rem_r, dvd_r[mgc_pkg::DvdW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_nxt = ge ? rem_sh - {1'b0, dvs_r} : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        dvd_r  <= req.dvd;
        dvs_r  <= req.dvs;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt[mgc_pkg::DvsW-1:0];
        dvd_r <= {dvd_r[mgc_pkg::DvdW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(mgc_pkg::DvdW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = dvd_r;
endmodule
`default_nettype wire

FILE: src/mic_agc_noise_gate_chain_top.sv
// Microphone conditioning chain: DC blocker, high-pass, low-pass, peak-tracking AGC,
// user volume, noise gate and soft limiter, turning one 32-bit mic slot word into one
// 16-bit PCM word. A sequencer walks each word through a shared 4-bit-digit multiplier
// and a shared 1-bit-per-cycle divider. While the gate ramps, each word needs one more
// product and one more quotient than when the gate is fully open or shut. The next word
// is taken as soon as the previous result sits in the output register.
// Depends on mgc_pkg, mgc_mul and mgc_div.
`default_nettype none
module mic_agc_noise_gate_chain_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_mic_slot,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_pcm_sample,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata
);
  logic [14:0] tp_r;
  logic [23:0] floor_r;
  logic [23:0] ceil_r;
  logic [15:0] slew_r;
  logic [3:0]  vol_r;

  mgc_pkg::state_t state_r, state_nxt;
  mgc_pkg::step_t  step_r, step_nxt;

  logic signed [31:0] x_r, x_nxt;
  logic signed [31:0] dc_in_r, dc_in_nxt;
  mgc_pkg::sig_t      dc_out_r, dc_out_nxt;
  mgc_pkg::sig_t      hp_in_r, hp_in_nxt;
  mgc_pkg::sig_t      hp_out_r, hp_out_nxt;
  mgc_pkg::sig_t      lp_r, lp_nxt;
  mgc_pkg::sig_t      s_r, s_nxt;
  logic [39:0]        pk_r, pk_nxt;
  logic [39:0]        env_r, env_nxt;
  logic [23:0]        gain_r, gain_nxt;
  logic [23:0]        aim_r, aim_nxt;
  mgc_pkg::wide_t     tmp_r, tmp_nxt;
  logic [15:0]        res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        out_pcm_r, out_pcm_nxt;

  mgc_pkg::mul_req_t mreq;
  mgc_pkg::mul_rsp_t mrsp;
  mgc_pkg::div_req_t dreq;
  mgc_pkg::div_rsp_t drsp;

  mgc_pkg::wide_t mp;
  mgc_pkg::wide_t mp_sh;
  mgc_pkg::wide_t gsum;
  logic [39:0]    band_abs;
  logic [39:0]    s_abs;
  logic           atk;
  logic [17:0]    umult;
  logic           unit_done;
  logic [mgc_pkg::DvdW-1:0] aim_lo;
  logic [mgc_pkg::DvdW-1:0] aim_cl;
  mgc_pkg::lim_t  lv;
  mgc_pkg::lim_t  lv_div;
  logic [15:0]    pcm_val;

  mgc_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
  mgc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign mp        = $signed(mrsp.p);
  assign mp_sh     = mp >>> 16;
  assign gsum      = mgc_pkg::MulPW'($signed({1'b0, gain_r})) + mp_sh;
  assign band_abs  = lp_r[39] ? 40'(-lp_r) : 40'(lp_r);
  assign s_abs     = s_r[39] ? 40'(-s_r) : 40'(s_r);
  assign atk       = band_abs > pk_r;
  assign umult     = mgc_pkg::K_USER_BASE + mgc_pkg::K_USER_STEP * 18'(vol_r);
  assign unit_done = (step_r == mgc_pkg::STP_AIM || step_r == mgc_pkg::STP_GDIV) ?
                     drsp.done : mrsp.done;
  assign aim_lo    = (drsp.q < mgc_pkg::DvdW'(floor_r)) ? mgc_pkg::DvdW'(floor_r) : drsp.q;
  assign aim_cl    = (aim_lo > mgc_pkg::DvdW'(ceil_r)) ? mgc_pkg::DvdW'(ceil_r) : aim_lo;

  always_comb begin
    lv = 42'(s_r);
    if (lv > mgc_pkg::LIM_KNEE) begin
      lv = mgc_pkg::LIM_KNEE + ((lv - mgc_pkg::LIM_KNEE) >>> 2);
    end else if (lv < -mgc_pkg::LIM_KNEE) begin
      lv = -mgc_pkg::LIM_KNEE + ((lv + mgc_pkg::LIM_KNEE) >>> 2);
    end
    if (lv > mgc_pkg::PCM_HI) begin
      lv = mgc_pkg::PCM_HI;
    end
    if (lv < mgc_pkg::PCM_LO) begin
      lv = mgc_pkg::PCM_LO;
    end
    if (lv < 0) begin
      lv_div = -((-lv) >>> 8);
    end else begin
      lv_div = lv >>> 8;
    end
    pcm_val = lv_div[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_r    <= 15'd12000;
      floor_r <= 24'd256;
      ceil_r  <= 24'd8192;
      slew_r  <= 16'd655;
      vol_r   <= 4'd4;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mgc_pkg::CFG_TARGET_PEAK:  tp_r    <= cfg_wdata[14:0];
        mgc_pkg::CFG_GAIN_FLOOR:   floor_r <= cfg_wdata;
        mgc_pkg::CFG_GAIN_CEILING: ceil_r  <= cfg_wdata;
        mgc_pkg::CFG_SLEW_RATE:    slew_r  <= cfg_wdata[15:0];
        mgc_pkg::CFG_VOLUME_STEP:  vol_r   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mgc_pkg::ST_IDLE;
      step_r      <= mgc_pkg::STP_DC;
      out_valid_r <= 1'b0;
      dc_in_r     <= '0;
      dc_out_r    <= '0;
      hp_in_r     <= '0;
      hp_out_r    <= '0;
      lp_r        <= '0;
      env_r       <= '0;
      pk_r        <= mgc_pkg::PEAK_RESET;
      gain_r      <= mgc_pkg::GAIN_RESET;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      dc_in_r     <= dc_in_nxt;
      dc_out_r    <= dc_out_nxt;
      hp_in_r     <= hp_in_nxt;
      hp_out_r    <= hp_out_nxt;
      lp_r        <= lp_nxt;
      env_r       <= env_nxt;
      pk_r        <= pk_nxt;
      gain_r      <= gain_nxt;
    end
    x_r       <= x_nxt;
    s_r       <= s_nxt;
    aim_r     <= aim_nxt;
    tmp_r     <= tmp_nxt;
    res_r     <= res_nxt;
    out_pcm_r <= out_pcm_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    x_nxt         = x_r;
    dc_in_nxt     = dc_in_r;
    dc_out_nxt    = dc_out_r;
    hp_in_nxt     = hp_in_r;
    hp_out_nxt    = hp_out_r;
    lp_nxt        = lp_r;
    s_nxt         = s_r;
    pk_nxt        = pk_r;
    env_nxt       = env_r;
    gain_nxt      = gain_r;
    aim_nxt       = aim_r;
    tmp_nxt       = tmp_r;
    res_nxt       = res_r;
    out_pcm_nxt   = out_pcm_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mreq          = '0;
    dreq          = '0;

    unique case (state_r)
      mgc_pkg::ST_IDLE: begin
        if (in_valid) begin
          x_nxt     = $signed({in_mic_slot[31:8], 8'h00});
          step_nxt  = mgc_pkg::STP_DC;
          state_nxt = mgc_pkg::ST_ISSUE;
        end
      end
      mgc_pkg::ST_ISSUE: begin
        state_nxt = mgc_pkg::ST_WAIT;
        case (step_r)
          mgc_pkg::STP_DC: begin
            mreq.start = 1'b1;
            mreq.a     = mgc_pkg::MulAW'(dc_out_r);
            mreq.b     = mgc_pkg::K_DC;
          end
          mgc_pkg::STP_HP: begin
            mreq.start = 1'b1;
            mreq.a     = mgc_pkg::MulAW'(hp_out_r) + mgc_pkg::MulAW'(dc_out_r)
                         - mgc_pkg::MulAW'(hp_in_r);
            mreq.b     = mgc_pkg::K_HP;
          end
          mgc_pkg::STP_LP: begin
            mreq.start = 1'b1;
            mreq.a     = mgc_pkg::MulAW'(hp_out_r) - mgc_pkg::MulAW'(lp_r);
            mreq.b     = mgc_pkg::K_LP;
          end
          mgc_pkg::STP_PK1: begin
            mreq.start = 1'b1;
            mreq.a     = mgc_pkg::MulAW'(pk_r);
            mreq.b     = atk ? mgc_pkg::K_ATK_KEEP : mgc_pkg::K_REL_KEEP;
          end
          mgc_pkg::STP_PK2: begin
            mreq.start = 1'b1;
            mreq.a     = mgc_pkg::MulAW'(band_abs);
            mreq.b     = atk ? mgc_pkg::K_ATK_NEW : mgc_pkg::K_REL_NEW;
          end
          mgc_pkg::STP_AIM: begin
            dreq.start = 1'b1;
            dreq.dvd   = mgc_pkg::DvdW'({tp_r, 24'd0});
            dreq.dvs   = mgc_pkg::DvsW'(pk_r) + mgc_pkg::DvsW'(256);
          end
          mgc_pkg::STP_SLEW: begin
            mreq.start = 1'b1;
            mreq.a     = mgc_pkg::MulAW'($signed({1'b0, aim_r}))
                         - mgc_pkg::MulAW'($signed({1'b0, gain_r}));
            mreq.b     = mgc_pkg::MulBW'(slew_r);
          end
          mgc_pkg::STP_GAIN: begin
            mreq.start = 1'b1;
            mreq.a     = mgc_pkg::MulAW'(lp_r);
            mreq.b     = gain_r;
          end
          mgc_pkg::STP_USER: begin
            mreq.start = 1'b1;
            mreq.a     = mgc_pkg::MulAW'(s_r);
            mreq.b     = mgc_pkg::MulBW'(umult);
          end
          mgc_pkg::STP_ENV1: begin
            mreq.start = 1'b1;
            mreq.a     = mgc_pkg::MulAW'(env_r);
            mreq.b     = mgc_pkg::K_ENV_KEEP;
          end
          mgc_pkg::STP_ENV2: begin
            mreq.start = 1'b1;
            mreq.a     = mgc_pkg::MulAW'(s_abs);
            mreq.b     = mgc_pkg::K_ENV_NEW;
          end
          mgc_pkg::STP_GMUL: begin
            if (env_r >= mgc_pkg::GATE_HIGH) begin
              step_nxt  = mgc_pkg::STP_FIN;
              state_nxt = mgc_pkg::ST_ISSUE;
            end else if (env_r <= mgc_pkg::GATE_LOW) begin
              s_nxt     = '0;
              step_nxt  = mgc_pkg::STP_FIN;
              state_nxt = mgc_pkg::ST_ISSUE;
            end else begin
              mreq.start = 1'b1;
              mreq.a     = mgc_pkg::MulAW'(s_abs);
              mreq.b     = mgc_pkg::MulBW'(env_r - mgc_pkg::GATE_LOW);
            end
          end
          mgc_pkg::STP_GDIV: begin
            dreq.start = 1'b1;
            dreq.dvd   = tmp_r[mgc_pkg::DvdW-1:0];
            dreq.dvs   = mgc_pkg::GATE_SPAN;
          end
          default: begin
            res_nxt   = pcm_val;
            state_nxt = mgc_pkg::ST_DONE;
          end
        endcase
      end
      mgc_pkg::ST_WAIT: begin
        if (unit_done) begin
          state_nxt = mgc_pkg::ST_ISSUE;
          case (step_r)
            mgc_pkg::STP_DC: begin
              dc_out_nxt = mgc_pkg::sat40(mgc_pkg::MulPW'(x_r) - mgc_pkg::MulPW'(dc_in_r) + mp_sh);
              dc_in_nxt  = x_r;
              step_nxt   = mgc_pkg::STP_HP;
            end
            mgc_pkg::STP_HP: begin
              hp_out_nxt = mgc_pkg::sat40(mp_sh);
              hp_in_nxt  = dc_out_r;
              step_nxt   = mgc_pkg::STP_LP;
            end
            mgc_pkg::STP_LP: begin
              lp_nxt   = mgc_pkg::sat40(mgc_pkg::MulPW'(lp_r) + mp_sh);
              step_nxt = mgc_pkg::STP_PK1;
            end
            mgc_pkg::STP_PK1: begin
              tmp_nxt  = mp;
              step_nxt = mgc_pkg::STP_PK2;
            end
            mgc_pkg::STP_PK2: begin
              pk_nxt   = 40'((tmp_r + mp) >>> 16);
              step_nxt = mgc_pkg::STP_AIM;
            end
            mgc_pkg::STP_AIM: begin
              aim_nxt  = aim_cl[23:0];
              step_nxt = mgc_pkg::STP_SLEW;
            end
            mgc_pkg::STP_SLEW: begin
              if (gsum < 0) begin
                gain_nxt = '0;
              end else if (gsum > mgc_pkg::MulPW'(mgc_pkg::GAIN_MAX)) begin
                gain_nxt = mgc_pkg::GAIN_MAX;
              end else begin
                gain_nxt = gsum[23:0];
              end
              step_nxt = mgc_pkg::STP_GAIN;
            end
            mgc_pkg::STP_GAIN: begin
              s_nxt    = mgc_pkg::sat40(mp_sh);
              step_nxt = mgc_pkg::STP_USER;
            end
            mgc_pkg::STP_USER: begin
              s_nxt    = mgc_pkg::sat40(mp_sh);
              step_nxt = mgc_pkg::STP_ENV1;
            end
            mgc_pkg::STP_ENV1: begin
              tmp_nxt  = mp;
              step_nxt = mgc_pkg::STP_ENV2;
            end
            mgc_pkg::STP_ENV2: begin
              env_nxt  = 40'((tmp_r + mp) >>> 16);
              step_nxt = mgc_pkg::STP_GMUL;
            end
            mgc_pkg::STP_GMUL: begin
              tmp_nxt  = mp;
              step_nxt = mgc_pkg::STP_GDIV;
            end
            mgc_pkg::STP_GDIV: begin
              s_nxt    = s_r[39] ? -$signed(drsp.q[39:0]) : $signed(drsp.q[39:0]);
              step_nxt = mgc_pkg::STP_FIN;
            end
            default: step_nxt = mgc_pkg::STP_FIN;
          endcase
        end
      end
      mgc_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_pcm_nxt   = res_r;
          state_nxt     = mgc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mgc_pkg::ST_IDLE;
    endcase
  end

  assign in_ready       = (state_r == mgc_pkg::ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_pcm_sample = out_pcm_r;
endmodule
`default_nettype wire

FILE: src/mgc_chk.sv
// Port-level checker for the microphone conditioning chain, bound to the top level.
// Depends on mic_agc_noise_gate_chain_top_defines.svh.
`default_nettype none
`include "mic_agc_noise_gate_chain_top_defines.svh"
module mgc_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_pcm_sample
);
  `MGC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `MGC_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_pcm_sample))
  `MGC_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready)
  `MGC_ASSERT_IMP(a_result_frees_input, $rose(out_valid), in_ready)
endmodule

bind mic_agc_noise_gate_chain_top mgc_chk u_mgc_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_pcm_sample(out_pcm_sample)
);
`default_nettype wire
